// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle assertion failed");

`endif

// ===== hw/rtl/bgir_pkg.sv =====
// ----------------------------------------------------------------------------
// bgir_pkg
// Types, constants and the discharge curve of the IR compensated gauge.
// ----------------------------------------------------------------------------
`default_nettype none

package bgir_pkg;

	localparam int CURVE_SLOTS        = 16;
	localparam int CURVE_POINTS_DEF   = 12;
	localparam int SEG_W              = 4;
	localparam int UV_W               = 23;
	localparam int PCT_W              = 7;
	localparam int AVG_W              = 27;
	localparam int QUOT_W             = 7;
	localparam int NUM_W              = UV_W + PCT_W;
	localparam int DVD_W              = NUM_W + 1;
	localparam int DVS_W              = UV_W + 1;
	localparam int S_TDATA_W          = 32;
	localparam int M_TDATA_W          = 40;
	localparam int CFG_IDX_W          = 2;
	localparam int CFG_DATA_W         = 16;

	localparam logic [CFG_IDX_W-1:0] REG_SAG     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CHG_THR = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SMOOTH  = 2'd2;

	localparam logic [7:0]         SAG_RST     = 8'd18;
	localparam logic signed [15:0] CHG_THR_RST = -16'sd200;
	localparam logic [2:0]         SMOOTH_RST  = 3'd2;

	localparam logic [7:0] PCT_UNMETERED = 8'hFF;

	localparam logic [UV_W-1:0] CURVE_UV [CURVE_SLOTS] = '{
		23'd4200000, 23'd4100000, 23'd4000000, 23'd3950000,
		23'd3880000, 23'd3830000, 23'd3790000, 23'd3750000,
		23'd3700000, 23'd3630000, 23'd3450000, 23'd3000000,
		23'd3000000, 23'd3000000, 23'd3000000, 23'd3000000
	};

	localparam logic [PCT_W-1:0] CURVE_PCT [CURVE_SLOTS] = '{
		7'd100, 7'd90, 7'd80, 7'd70, 7'd60, 7'd50, 7'd40, 7'd30,
		7'd20, 7'd10, 7'd5, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0
	};

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PROD,
		ST_REST,
		ST_AVG,
		ST_SEG,
		ST_MUL,
		ST_DLOAD,
		ST_DIV,
		ST_DONE
	} bgir_state_t;

	typedef struct packed {
		logic load_in;
		logic do_prod;
		logic do_rest;
		logic do_avg;
		logic do_seg;
		logic do_mul;
		logic div_start;
		logic load_out;
	} bgir_cmd_t;

	typedef struct packed {
		logic div_done;
	} bgir_sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/battery_gauge_ir_compensated_unit.sv =====
// ----------------------------------------------------------------------------
// battery_gauge_ir_compensated_unit
// Voltage based fuel gauge with load compensation and a smoothed rest voltage.
// ----------------------------------------------------------------------------
// Each sample enters on the s_ channel and yields exactly one result on the
// m_ channel. A sample carries the raw bus register and the shunt register in
// s_tdata and the read status in s_tuser. A result carries the bus voltage,
// current, charging flag and charge percent in m_tdata, and the metered flag
// in m_tuser. Configuration registers are written over cfg_valid, cfg_index
// and cfg_data; the user must write them only while no sample is in flight,
// as the block itself does not enforce it. A good sample passes through the
// product, rest, average, segment, multiply and divider load steps and then
// the restoring divider of the curve interpolation; a failed read skips them
// and goes straight to the output register. The block works on one sample at
// a time and takes the next one once its result sits in the output register.
// If the receiver stalls, the finished result is held and the next sample
// waits at the end of its computation. Reset clears the average, empties the
// output register and restores the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module battery_gauge_ir_compensated_unit #(
	parameter int CURVE_POINTS = bgir_pkg::CURVE_POINTS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	// bus_raw [15:0], shunt_raw [31:16]
	input  wire logic [bgir_pkg::S_TDATA_W-1:0]  s_tdata,
	// read_ok
	input  wire logic                            s_tuser,
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	// bus_mv [14:0], current_count [30:15], charging [31], charge_percent [39:32]
	output logic [bgir_pkg::M_TDATA_W-1:0]       m_tdata,
	// metered
	output logic                                 m_tuser,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [bgir_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [bgir_pkg::CFG_DATA_W-1:0] cfg_data
);

	import bgir_pkg::*;

	bgir_cmd_t cmd;
	bgir_sts_t sts;

	assign cfg_ready = 1'b1;

	bgir_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ok     (s_tuser),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.cmd       (cmd),
		.sts       (sts)
	);

	bgir_dp #(
		.CURVE_POINTS (CURVE_POINTS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.in_data     (s_tdata),
		.in_ok       (s_tuser),
		.cfg_we      (cfg_valid),
		.cfg_idx     (cfg_index),
		.cfg_wdata   (cfg_data),
		.out_data    (m_tdata),
		.out_metered (m_tuser)
	);

endmodule

`default_nettype wire

// ===== hw/rtl/bgir_div.sv =====
// ----------------------------------------------------------------------------
// bgir_div
// Restoring divider producing one quotient bit per cycle, MSB first.
// ----------------------------------------------------------------------------
`default_nettype none

module bgir_div #(
	parameter int DVD_W  = bgir_pkg::DVD_W,
	parameter int DVS_W  = bgir_pkg::DVS_W,
	parameter int QUOT_W = bgir_pkg::QUOT_W
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [DVD_W-1:0]  dividend,
	input  wire logic [DVS_W-1:0]  divisor,
	output logic                   done,
	output logic [QUOT_W-1:0]      quot
);

	localparam int DEN_W = DVS_W + QUOT_W - 1;
	localparam int CNT_W = (QUOT_W > 1) ? $clog2(QUOT_W) : 1;

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DVD_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [QUOT_W-1:0] quot_q;
	logic             fits;

	assign fits = rem_q >= DVD_W'(den_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(QUOT_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= dividend;
			den_q  <= {divisor, {(QUOT_W - 1){1'b0}}};
			quot_q <= '0;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= rem_q - DVD_W'(den_q);
			end
			quot_q <= {quot_q[QUOT_W-2:0], fits};
			den_q  <= den_q >> 1;
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

`default_nettype wire

// ===== hw/rtl/bgir_dp.sv =====
// ----------------------------------------------------------------------------
// bgir_dp
// Datapath: registers, resting voltage, moving average, curve lookup.
// ----------------------------------------------------------------------------
`default_nettype none

module bgir_dp #(
	parameter int CURVE_POINTS = bgir_pkg::CURVE_POINTS_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire bgir_pkg::bgir_cmd_t                  cmd,
	output bgir_pkg::bgir_sts_t                       sts,
	input  wire logic [bgir_pkg::S_TDATA_W-1:0]       in_data,
	input  wire logic                                 in_ok,
	input  wire logic                                 cfg_we,
	input  wire logic [bgir_pkg::CFG_IDX_W-1:0]       cfg_idx,
	input  wire logic [bgir_pkg::CFG_DATA_W-1:0]      cfg_wdata,
	output logic [bgir_pkg::M_TDATA_W-1:0]            out_data,
	output logic                                      out_metered
);

	import bgir_pkg::*;

	logic [7:0]                sag_q;
	logic signed [15:0]        chg_thr_q;
	logic [2:0]                smooth_q;

	logic                      ok_q;
	logic [14:0]               bus_mv_q;
	logic signed [15:0]        cur_q;
	logic signed [24:0]        prod_q;
	logic [24:0]               bmv_k_q;
	logic signed [AVG_W-1:0]   rest_q;
	logic signed [AVG_W-1:0]   avg_q;

	logic                      direct_q;
	logic [PCT_W-1:0]          direct_pct_q;
	logic [PCT_W-1:0]          lo_pct_q;
	logic [UV_W-1:0]           diff_q;
	logic [PCT_W-1:0]          dp_q;
	logic [UV_W-1:0]           span_q;
	logic [NUM_W-1:0]          num_q;

	logic                      out_metered_q;
	logic [M_TDATA_W-1:0]      out_data_q;

	logic signed [AVG_W:0]     avg_diff;
	logic signed [AVG_W:0]     avg_step;
	logic                      top_hit;
	logic                      seg_hit;
	logic [SEG_W-1:0]          seg_idx;
	logic [SEG_W-1:0]          seg_up;
	logic [UV_W-1:0]           seg_span;
	logic [UV_W-1:0]           seg_diff;
	logic [DVD_W-1:0]          div_dvd;
	logic [DVS_W-1:0]          div_dvs;
	logic                      div_done;
	logic [QUOT_W-1:0]         div_quot;
	logic [PCT_W-1:0]          pct_final;
	logic                      charging;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sag_q     <= SAG_RST;
			chg_thr_q <= CHG_THR_RST;
			smooth_q  <= SMOOTH_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_SAG:     sag_q     <= cfg_wdata[7:0];
				REG_CHG_THR: chg_thr_q <= $signed(cfg_wdata);
				REG_SMOOTH:  smooth_q  <= cfg_wdata[2:0];
				default:     ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			avg_q <= '0;
		end else if (cmd.do_avg) begin
			if (avg_q == '0) begin
				avg_q <= rest_q;
			end else begin
				avg_q <= avg_q + avg_step[AVG_W-1:0];
			end
		end
	end

	assign avg_diff = $signed({rest_q[AVG_W-1], rest_q}) - $signed({avg_q[AVG_W-1], avg_q});
	assign avg_step = avg_diff >>> smooth_q;

	always_comb begin
		top_hit = avg_q >= $signed({{(AVG_W - UV_W){1'b0}}, CURVE_UV[0]});
		seg_hit = 1'b0;
		seg_idx = '0;
		for (int i = CURVE_POINTS - 1; i >= 1; i--) begin
			if (avg_q >= $signed({{(AVG_W - UV_W){1'b0}}, CURVE_UV[i]})) begin
				seg_hit = 1'b1;
				seg_idx = SEG_W'(i);
			end
		end
		seg_up   = seg_idx - 1'b1;
		seg_span = CURVE_UV[seg_up] - CURVE_UV[seg_idx];
		seg_diff = avg_q[UV_W-1:0] - CURVE_UV[seg_idx];
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			ok_q     <= in_ok;
			bus_mv_q <= {in_data[15:3], 2'b00};
			cur_q    <= $signed(in_data[31:16]);
		end
		if (cmd.do_prod) begin
			prod_q  <= cur_q * $signed({1'b0, sag_q});
			bmv_k_q <= 25'(bus_mv_q) * 25'd1000;
		end
		if (cmd.do_rest) begin
			rest_q <= $signed({2'b00, bmv_k_q}) + AVG_W'(prod_q);
		end
		if (cmd.do_seg) begin
			lo_pct_q <= CURVE_PCT[seg_idx];
			dp_q     <= CURVE_PCT[seg_up] - CURVE_PCT[seg_idx];
			span_q   <= seg_span;
			diff_q   <= seg_diff;
			if (top_hit) begin
				direct_q     <= 1'b1;
				direct_pct_q <= CURVE_PCT[0];
			end else if (!seg_hit) begin
				direct_q     <= 1'b1;
				direct_pct_q <= '0;
			end else begin
				direct_q     <= seg_span == '0;
				direct_pct_q <= CURVE_PCT[seg_idx];
			end
		end
		if (cmd.do_mul) begin
			num_q <= NUM_W'(diff_q) * NUM_W'(dp_q);
		end
		if (cmd.load_out) begin
			out_metered_q <= ok_q;
			if (ok_q) begin
				out_data_q <= {1'b0, pct_final, charging, cur_q, bus_mv_q};
			end else begin
				out_data_q <= {PCT_UNMETERED, 32'd0};
			end
		end
	end

	assign div_dvd = {num_q, 1'b0} + DVD_W'(span_q);
	assign div_dvs = {span_q, 1'b0};

	bgir_div #(
		.DVD_W  (DVD_W),
		.DVS_W  (DVS_W),
		.QUOT_W (QUOT_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.done     (div_done),
		.quot     (div_quot)
	);

	assign pct_final = direct_q ? direct_pct_q : lo_pct_q + div_quot;
	assign charging  = cur_q < chg_thr_q;

	assign sts.div_done = div_done;
	assign out_data     = out_data_q;
	assign out_metered  = out_metered_q;

endmodule

`default_nettype wire

// ===== hw/rtl/bgir_ctrl.sv =====
// ----------------------------------------------------------------------------
// bgir_ctrl
// Sequencer that steps one sample through the datapath and owns the handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module bgir_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	input  wire logic                in_ok,
	output logic                     in_ready,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output bgir_pkg::bgir_cmd_t      cmd,
	input  wire bgir_pkg::bgir_sts_t sts
);

	import bgir_pkg::*;

	bgir_state_t state_q;
	bgir_state_t state_d;
	logic        out_valid_q;
	logic        out_free;

	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = in_ok ? ST_PROD : ST_DONE;
				end
			end
			ST_PROD:  state_d = ST_REST;
			ST_REST:  state_d = ST_AVG;
			ST_AVG:   state_d = ST_SEG;
			ST_SEG:   state_d = ST_MUL;
			ST_MUL:   state_d = ST_DLOAD;
			ST_DLOAD: state_d = ST_DIV;
			ST_DIV: begin
				if (sts.div_done) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd           = '0;
		in_ready      = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.load_in = in_valid;
			end
			ST_PROD:  cmd.do_prod   = 1'b1;
			ST_REST:  cmd.do_rest   = 1'b1;
			ST_AVG:   cmd.do_avg    = 1'b1;
			ST_SEG:   cmd.do_seg    = 1'b1;
			ST_MUL:   cmd.do_mul    = 1'b1;
			ST_DLOAD: cmd.div_start = 1'b1;
			ST_DIV:   ;
			ST_DONE:  cmd.load_out  = out_free;
			default:  ;
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

// ===== hw/rtl/bgir_chk.sv =====
// ----------------------------------------------------------------------------
// bgir_chk
// Port level checks of the gauge, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module bgir_chk (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [39:0] m_tdata,
	input wire logic        m_tuser
);

	`ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid)

	`ASSERT_NEXT(a_one_in_flight, clk, arst_n, s_tvalid && s_tready, !s_tready)

	`ASSERT_SAME(a_unmetered_fields, clk, arst_n, m_tvalid && !m_tuser, m_tdata == 40'hFF_0000_0000)

	`ASSERT_SAME(a_pct_range, clk, arst_n, m_tvalid && m_tuser, !m_tdata[39] && m_tdata[38:32] <= 7'd100)

endmodule

bind battery_gauge_ir_compensated_unit bgir_chk u_bgir_chk (.*);

`default_nettype wire

// ===== sim/tb_battery_gauge_ir_compensated_unit.sv =====
// ----------------------------------------------------------------------------
// tb_battery_gauge_ir_compensated_unit
// Self-checking testbench for the load compensated battery gauge.
// ----------------------------------------------------------------------------
// Samples go in on the input stream and readings come back on the output
// stream. A scoreboard class keeps its own copy of the registers and of the
// smoothed rest voltage, works out the reading each accepted sample should give
// and checks every returned reading against the oldest one still waiting.
// A short directed part covers the field extremes, failed reads, the charging
// threshold edge and the curve ends. Random phases follow under several
// register settings, with random idling on both streams but in one phase,
// one long receiver hold-off and a drain of the block after each phase.
// ----------------------------------------------------------------------------

module tb_battery_gauge_ir_compensated_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import bgir_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
	localparam int CURVE_N = 12;
	localparam int PHASE_ITEMS = 130;

	typedef struct packed {
		logic               metered;
		logic [14:0]        bus_mv;
		logic signed [15:0] current;
		logic               charging;
		logic signed [7:0]  pct;
	} reading_t;

	class gauge_scoreboard;
		reading_t           expected_q[$];
		logic [7:0]         sag;
		logic signed [15:0] thr;
		logic [2:0]         shift_w;
		longint             rest_avg;
		int                 errors;

		function new();
			sag = 8'd18;
			thr = -16'sd200;
			shift_w = 3'd2;
			rest_avg = 0;
			errors = 0;
		endfunction

		function longint knee_uv(int i);
			case (i)
				0: return 4200000;
				1: return 4100000;
				2: return 4000000;
				3: return 3950000;
				4: return 3880000;
				5: return 3830000;
				6: return 3790000;
				7: return 3750000;
				8: return 3700000;
				9: return 3630000;
				10: return 3450000;
				default: return 3000000;
			endcase
		endfunction

		function longint knee_pct(int i);
			case (i)
				0: return 100;
				1: return 90;
				2: return 80;
				3: return 70;
				4: return 60;
				5: return 50;
				6: return 40;
				7: return 30;
				8: return 20;
				9: return 10;
				10: return 5;
				default: return 0;
			endcase
		endfunction

		function longint percent_for_uv(longint uv);
			longint hi;
			longint lo;
			longint span;
			longint num;
			if (uv >= knee_uv(0))
				return knee_pct(0);
			for (int i = 1; i < CURVE_N; i++) begin
				hi = knee_uv(i - 1);
				lo = knee_uv(i);
				if (uv >= lo) begin
					span = hi - lo;
					if (span <= 0)
						return knee_pct(i);
					num = (uv - lo) * (knee_pct(i - 1) - knee_pct(i));
					return knee_pct(i) + (2 * num + span) / (2 * span);
				end
			end
			return 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_SAG: sag = data[7:0];
				REG_CHG_THR: thr = data;
				REG_SMOOTH: shift_w = data[2:0];
				default: ;
			endcase
		endfunction

		function void note_reading(logic [15:0] bus, logic [15:0] shunt, logic ok);
			reading_t e;
			longint mv;
			longint cur;
			longint rest;
			e = '0;
			if (!ok) begin
				e.pct = PCT_UNMETERED;
			end else begin
				mv = longint'(bus >> 3) * 4;
				cur = longint'($signed(shunt));
				rest = mv * 1000 + cur * longint'(sag);
				if (rest_avg == 0)
					rest_avg = rest;
				else
					rest_avg = rest_avg + ((rest - rest_avg) >>> shift_w);
				e.metered = 1'b1;
				e.bus_mv = mv[14:0];
				e.current = shunt;
				e.charging = cur < longint'(thr);
				e.pct = 8'(percent_for_uv(rest_avg));
			end
			expected_q.push_back(e);
		endfunction

		task report(string what, longint expv, longint gotv);
			$display("mismatch in %s: expected %0d, got %0d", what, expv, gotv);
			errors++;
		endtask

		task check_reading(reading_t got);
			reading_t e;
			if (expected_q.size() == 0) begin
				report("unexpected reading, metered", -1, got.metered);
			end else begin
				e = expected_q.pop_front();
				if (got.metered !== e.metered)
					report("metered", e.metered, got.metered);
				if (got.bus_mv !== e.bus_mv)
					report("bus_mv", e.bus_mv, got.bus_mv);
				if (got.current !== e.current)
					report("current_count", e.current, got.current);
				if (got.charging !== e.charging)
					report("charging", e.charging, got.charging);
				if (got.pct !== e.pct)
					report("charge_percent", e.pct, got.pct);
			end
		endtask
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [S_TDATA_W-1:0]  s_tdata;
	logic                  s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [M_TDATA_W-1:0]  m_tdata;
	logic                  m_tuser;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	logic calm;
	logic hold_req;
	reading_t got_reading;

	gauge_scoreboard sb = new();

	battery_gauge_ir_compensated_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#3_000_000;
		$display("FAIL battery_gauge_ir_compensated_unit");
		$finish;
	end

	assign got_reading = '{metered: m_tuser, bus_mv: m_tdata[14:0], current: m_tdata[30:15],
		charging: m_tdata[31], pct: m_tdata[39:32]};

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_reading(got_reading);
		if (arst_n && s_tvalid && s_tready)
			sb.note_reading(s_tdata[15:0], s_tdata[31:16], s_tuser);
		if (arst_n && cfg_valid && cfg_ready)
			sb.write_reg(cfg_index, cfg_data);
	end

	// Receiver: random back-pressure, or one long hold-off on request.
	initial begin
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				m_tready <= 1'b0;
				repeat (400) @(posedge clk);
			end else begin
				m_tready <= calm || ($urandom_range(99) >= 25);
			end
		end
	end

	function automatic logic [15:0] mv_to_raw(int mv);
		return 16'((mv / 4) << 3);
	endfunction

	function automatic int idle_gap();
		if (calm || $urandom_range(99) >= 25)
			return 0;
		return $urandom_range(1, 6);
	endfunction

	task automatic send_reading(input logic [15:0] bus, input logic [15:0] shunt,
		input logic ok, input int gap);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {shunt, bus};
		s_tuser <= ok;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic send_random();
		logic [15:0] bus;
		logic [15:0] shunt;
		logic ok;
		int pick;
		ok = $urandom_range(99) >= 8;
		pick = $urandom_range(99);
		if (pick < 12)
			bus = 16'($urandom);
		else if (pick < 30)
			bus = mv_to_raw(int'(sb.knee_uv($urandom_range(CURVE_N - 1)) / 1000))
				| 16'($urandom_range(7));
		else
			bus = 16'(($urandom_range(700, 1100) << 3) | $urandom_range(7));
		pick = $urandom_range(99);
		if (pick < 15)
			shunt = 16'($urandom);
		else if (pick < 27)
			shunt = sb.thr + 16'($urandom_range(2)) - 16'd1;
		else if (pick < 40)
			shunt = 16'd0;
		else
			shunt = 16'($urandom_range(4000)) - 16'd2000;
		send_reading(bus, shunt, ok, idle_gap());
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic configure(input logic [7:0] sag, input logic signed [15:0] thr,
		input logic [2:0] shift_v);
		write_register(REG_SAG, {8'd0, sag});
		write_register(REG_CHG_THR, thr);
		write_register(REG_SMOOTH, {13'd0, shift_v});
		write_register(REG_SPARE, 16'($urandom));
	endtask

	task automatic random_phase(input int items);
		for (int i = 0; i < items; i++)
			send_random();
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		calm = 1'b0;
		hold_req = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);

		// Directed part under the reset register values.
		send_reading(16'hFFFF, 16'h8000, 1'b0, 0);
		send_reading(16'h0000, 16'h0000, 1'b1, 0);
		send_reading(16'hFFFF, 16'h7FFF, 1'b1, 0);
		send_reading(16'h0007, 16'h8000, 1'b1, 2);
		send_reading(16'h0000, 16'hFFFF, 1'b0, 0);
		send_reading(mv_to_raw(5000), -16'sd200, 1'b1, 0);
		send_reading(mv_to_raw(4300), -16'sd201, 1'b1, 1);
		send_reading(mv_to_raw(4200), -16'sd199, 1'b1, 0);
		for (int k = 1; k < CURVE_N; k++)
			send_reading(mv_to_raw(int'(sb.knee_uv(k) / 1000)), 16'($urandom_range(40)),
				1'b1, 0);
		send_reading(mv_to_raw(3200), 16'h0000, 1'b0, 0);
		send_reading(mv_to_raw(2900), 16'h0000, 1'b1, 0);
		send_reading(mv_to_raw(2000), 16'h7FFF, 1'b1, 0);
		send_reading(16'h0000, 16'h8000, 1'b1, 0);
		random_phase(PHASE_ITEMS);
		drain();

		// Lowest settings: no sag, threshold at zero, no smoothing.
		configure(8'd0, 16'sd0, 3'd0);
		send_reading(16'h0000, 16'h0000, 1'b1, 0);
		hold_req = 1'b1;
		random_phase(PHASE_ITEMS);
		drain();

		// Highest settings, with no idling on either side.
		configure(8'd255, -16'sd32768, 3'd7);
		calm = 1'b1;
		random_phase(PHASE_ITEMS);
		calm = 1'b0;
		drain();

		configure(8'($urandom), -16'sd1 * 16'($urandom_range(32768)), 3'($urandom));
		random_phase(PHASE_ITEMS / 2);
		drain();
		random_phase(PHASE_ITEMS - PHASE_ITEMS / 2);
		drain();

		configure(8'($urandom_range(1, 254)), -16'sd1 * 16'($urandom_range(1000)),
			3'($urandom_range(1, 6)));
		random_phase(PHASE_ITEMS);
		drain();
		repeat (40) @(posedge clk);

		if (sb.errors == 0)
			$display("PASS battery_gauge_ir_compensated_unit");
		else
			$display("FAIL battery_gauge_ir_compensated_unit");
		$finish;
	end

endmodule
